// ----- hdl/hvt_pkg.sv -----
// Shared types and constants for the homogeneous vertex transform unit.
package hvt_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned DIV_STEPS = 32;
  // products, row sums, divider preparation, divider steps, output register
  localparam int unsigned NUM_STAGES = 3 + DIV_STEPS + 1;

  typedef enum logic [2:0] {
    FUNC_LOAD       = 3'd0,
    FUNC_IDENTITY   = 3'd1,
    FUNC_AFFINE     = 3'd2,
    FUNC_DIRECTION  = 3'd3,
    FUNC_PROJECTIVE = 3'd4
  } func_t;

  // Result of one divider lane: quotient magnitude, sign and overflow.
  typedef struct packed {
    logic [COORD_W-1:0] quot;
    logic               neg;
    logic               big;
  } div_res_t;

endpackage

// ----- hdl/hvt_lane.sv -----
// One row lane: three coefficient products, floor shift and row sum.
module hvt_lane #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned SUM_W     = 51
) (
  input  logic                             clk,
  input  logic                             en_prod,
  input  logic                             en_sum,
  input  logic signed [hvt_pkg::COORD_W-1:0] m0,
  input  logic signed [hvt_pkg::COORD_W-1:0] m1,
  input  logic signed [hvt_pkg::COORD_W-1:0] m2,
  input  logic signed [hvt_pkg::COORD_W-1:0] m3,
  input  logic signed [hvt_pkg::COORD_W-1:0] x,
  input  logic signed [hvt_pkg::COORD_W-1:0] y,
  input  logic signed [hvt_pkg::COORD_W-1:0] z,
  input  logic                             use_t,
  output logic signed [SUM_W-1:0]          sum
);

  localparam int unsigned PW = 2 * hvt_pkg::COORD_W;

  logic signed [PW-1:0] p0, p1, p2;
  logic signed [PW-1:0] s0, s1, s2;
  logic signed [hvt_pkg::COORD_W-1:0] t;

  // Register the exact products and the translation term
  always_ff @(posedge clk) begin
    if (en_prod) begin
      p0 <= PW'(m0) * PW'(x);
      p1 <= PW'(m1) * PW'(y);
      p2 <= PW'(m2) * PW'(z);
      t  <= use_t ? m3 : '0;
    end
  end

  // Floor shift: arithmetic shift rounds toward minus infinity
  assign s0 = p0 >>> FRAC_BITS;
  assign s1 = p1 >>> FRAC_BITS;
  assign s2 = p2 >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en_sum) begin
      sum <= s0[SUM_W-1:0] + s1[SUM_W-1:0] + s2[SUM_W-1:0]
           + {{(SUM_W-hvt_pkg::COORD_W){t[hvt_pkg::COORD_W-1]}}, t};
    end
  end

endmodule

// ----- hdl/hvt_div.sv -----
// Pipelined restoring divider: (n << FRAC_BITS) / d, one quotient bit a stage.
module hvt_div #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned SUM_W     = 51
) (
  input  logic                           clk,
  input  logic [hvt_pkg::DIV_STEPS:0]    en,
  input  logic signed [SUM_W-1:0]        n,
  input  logic signed [SUM_W-1:0]        d,
  output hvt_pkg::div_res_t              res
);

  localparam int unsigned STEPS = hvt_pkg::DIV_STEPS;
  localparam int unsigned W     = SUM_W + STEPS;

  logic [W-1:0]           rem  [0:STEPS];
  logic [STEPS-1:0]       quot [0:STEPS];
  logic [SUM_W-1:0]       dmag [0:STEPS];
  logic [STEPS:0]         neg;
  logic [STEPS:0]         big;

  logic [SUM_W-1:0] un, ud;
  logic [W-1:0]     nsh;

  // Take magnitudes and check whether the quotient needs more than 32 bits
  assign un  = n[SUM_W-1] ? SUM_W'(-n) : SUM_W'(n);
  assign ud  = d[SUM_W-1] ? SUM_W'(-d) : SUM_W'(d);
  assign nsh = W'(un) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0]  <= nsh;
      quot[0] <= '0;
      dmag[0] <= ud;
      neg[0]  <= n[SUM_W-1] ^ d[SUM_W-1];
      big[0]  <= nsh >= {ud, {STEPS{1'b0}}};
    end
  end

  // One subtract and compare per stage, most significant bit first
  for (genvar s = 1; s <= STEPS; s++) begin : g_step
    logic [W-1:0] dsh;
    logic         ge;
    assign dsh = W'(dmag[s-1]) << (STEPS - s);
    assign ge  = rem[s-1] >= dsh;
    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem[s]  <= ge ? rem[s-1] - dsh : rem[s-1];
        quot[s] <= {quot[s-1][STEPS-2:0], ge};
        dmag[s] <= dmag[s-1];
        neg[s]  <= neg[s-1];
        big[s]  <= big[s-1];
      end
    end
  end

  assign res.quot = quot[STEPS];
  assign res.neg  = neg[STEPS];
  assign res.big  = big[STEPS];

endmodule

// ----- hdl/homogeneous_vertex_transform.sv -----
// Top level of the homogeneous vertex transform unit: matrix, lanes, merge.
// Holds a 4x4 Q-format matrix (identity after reset) and transforms one point
// per clock unless the output stalls. Coefficient loads and identity resets take
// effect in the cycle they are accepted and give no result; a later point sees
// the new matrix. Points go through a 36-stage pipeline: products, row sums,
// divider set-up, 32 divider steps (one quotient bit each) and an output
// register. Affine and direction points pass the same divider with a divisor
// of 1.0, which yields the saturated sum. A stalled output holds back only as
// many stages as are full.
module homogeneous_vertex_transform #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [3:0]  coeff_index,
  input  logic signed [31:0] coeff_value,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic        saturated
);

  localparam int unsigned CW    = hvt_pkg::COORD_W;
  localparam int unsigned NS    = hvt_pkg::NUM_STAGES;
  localparam int unsigned SUM_W = 2 * CW - FRAC_BITS + 3;
  localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;
  localparam logic [SUM_W-1:0] ONE_S = SUM_W'(1) << FRAC_BITS;

  logic signed [CW-1:0] coeffs [0:15];
  logic              fire;
  logic              v0;
  logic [NS:1]       v, v_next, en;
  logic [NS+1:1]     rdy;
  logic              is_dir, proj1, proj2;
  logic signed [SUM_W-1:0] sums [0:3];
  logic signed [SUM_W-1:0] wdiv;
  hvt_pkg::div_res_t dres [0:2];
  logic [CW-1:0]     rval [0:2];
  logic [2:0]        rsat;
  hvt_pkg::func_t    fcode;

  assign fcode = hvt_pkg::func_t'(func);
  assign fire  = in_valid && in_ready;
  assign v0    = fire && (fcode == hvt_pkg::FUNC_AFFINE || fcode == hvt_pkg::FUNC_DIRECTION
                          || fcode == hvt_pkg::FUNC_PROJECTIVE);
  assign is_dir = fcode == hvt_pkg::FUNC_DIRECTION;

  // Matrix: load one coefficient or restore the identity
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) coeffs[i] <= (i % 5 == 0) ? ONE_C : '0;
    end else if (fire) begin
      unique case (fcode)
        hvt_pkg::FUNC_LOAD: coeffs[coeff_index] <= coeff_value;
        hvt_pkg::FUNC_IDENTITY: begin
          for (int i = 0; i < 16; i++) coeffs[i] <= (i % 5 == 0) ? ONE_C : '0;
        end
        default: ;
      endcase
    end
  end

  // Stage ready chain: a stage advances when empty or when the next one advances
  always_comb begin
    rdy[NS+1] = out_ready;
    for (int i = NS; i >= 1; i--) rdy[i] = !v[i] || rdy[i+1];
  end
  assign en       = rdy[NS:1];
  assign in_ready = rdy[1];

  always_comb begin
    v_next[1] = en[1] ? v0 : v[1];
    for (int i = 2; i <= NS; i++) begin
      v_next[i] = en[i] ? v[i-1] : v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= v_next;
    end
  end

  // Track projective mode through the product and sum stages
  always_ff @(posedge clk) begin
    if (en[1]) proj1 <= fcode == hvt_pkg::FUNC_PROJECTIVE;
    if (en[2]) proj2 <= proj1;
  end

  // Four row lanes; the fourth gives w
  for (genvar r = 0; r < 4; r++) begin : g_lane
    hvt_lane #(.FRAC_BITS(FRAC_BITS), .SUM_W(SUM_W)) u_lane (
      .clk     (clk),
      .en_prod (en[1]),
      .en_sum  (en[2]),
      .m0      (coeffs[r*4]),
      .m1      (coeffs[r*4+1]),
      .m2      (coeffs[r*4+2]),
      .m3      (coeffs[r*4+3]),
      .x       (point_x),
      .y       (point_y),
      .z       (point_z),
      .use_t   ((r == 3) || !is_dir),
      .sum     (sums[r])
    );
  end

  // Divide by w in projective mode (zero taken as one), else by one
  assign wdiv = (proj2 && sums[3] != '0) ? sums[3] : ONE_S;

  for (genvar c = 0; c < 3; c++) begin : g_div
    hvt_div #(.FRAC_BITS(FRAC_BITS), .SUM_W(SUM_W)) u_div (
      .clk (clk),
      .en  (en[NS-1:3]),
      .n   (sums[c]),
      .d   (wdiv),
      .res (dres[c])
    );

    // Merge: apply sign and clip to 32 bits
    always_comb begin
      rsat[c] = dres[c].big || (dres[c].neg ? (dres[c].quot > 32'h8000_0000)
                                            : dres[c].quot[CW-1]);
      if (rsat[c]) begin
        rval[c] = dres[c].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        rval[c] = dres[c].neg ? -dres[c].quot : dres[c].quot;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en[NS]) begin
      out_x     <= rval[0];
      out_y     <= rval[1];
      out_z     <= rval[2];
      saturated <= |rsat;
    end
  end
  assign out_valid = v[NS];

  // Input is held off only when every stage is full and the output is stalled
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&v) && !out_ready) else $error("input stalled with room in pipe");

  a_load: assert property (@(posedge clk) disable iff (rst)
    fire && fcode == hvt_pkg::FUNC_LOAD |=>
      coeffs[$past(coeff_index)] == $past(coeff_value)) else $error("coefficient not loaded");

  a_ident: assert property (@(posedge clk) disable iff (rst)
    fire && fcode == hvt_pkg::FUNC_IDENTITY |=>
      coeffs[0] == ONE_C && coeffs[1] == '0 && coeffs[15] == ONE_C)
    else $error("identity not restored");

endmodule
